// ===== src/svalloc_pkg.sv =====
// Shared types, command codes and sizes for the voice allocator.
package svalloc_pkg;

  localparam int NUM_VOICES      = 18;
  localparam int NUM_CHANNELS    = 16;
  localparam int VOICE_W         = 5;
  localparam int AGE_W           = 32;
  localparam int PEDAL_THRESHOLD = 64;

  // Input commands
  localparam logic [2:0] CMD_NOTE_ON       = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF      = 3'd1;
  localparam logic [2:0] CMD_PEDAL         = 3'd2;
  localparam logic [2:0] CMD_ALL_NOTES_OFF = 3'd3;
  localparam logic [2:0] CMD_RESET_CTRL    = 3'd4;
  localparam logic [2:0] CMD_ALL_OFF       = 3'd5;
  localparam logic [2:0] CMD_BANK_CHANGE   = 3'd6;

  // Result event codes
  localparam logic [1:0] EV_KEY_ON  = 2'd0;
  localparam logic [1:0] EV_KEY_OFF = 2'd1;
  localparam logic [1:0] EV_HELD    = 2'd2;

  // What a cell does when the scan token passes it
  localparam logic [2:0] SCAN_PICK     = 3'd0;
  localparam logic [2:0] SCAN_NOTE_OFF = 3'd1;
  localparam logic [2:0] SCAN_REL_HELD = 3'd2;
  localparam logic [2:0] SCAN_CH_OFF   = 3'd3;
  localparam logic [2:0] SCAN_ALL_OFF  = 3'd4;

  // Operations broadcast to the selected cell
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_KILL  = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;

  // Allocation preference, lower wins
  localparam logic [1:0] RANK_IDLE = 2'd0;
  localparam logic [1:0] RANK_HELD = 2'd1;
  localparam logic [1:0] RANK_ON   = 2'd2;
  localparam logic [1:0] RANK_NONE = 2'd3;

  typedef struct packed {
    logic               vld;
    logic               done;
    logic [1:0]         rank;
    logic [AGE_W-1:0]   age;
    logic [VOICE_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic               vld;
    logic [1:0]         ev;
    logic [VOICE_W-1:0] voice;
    logic [3:0]         channel;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic               reload;
    logic [7:0]         patch;
  } res_t;

  typedef struct packed {
    logic               adv;
    logic [2:0]         mode;
    logic [3:0]         channel;
    logic [6:0]         note;
    logic               pedal;
    logic [1:0]         op;
    logic [VOICE_W-1:0] sel;
    logic [6:0]         velocity;
    logic [7:0]         patch;
    logic [AGE_W-1:0]   age;
    logic               clr_patch;
  } ctl_t;

endpackage

// ===== src/svalloc_cell.sv =====
// One voice cell: holds the voice state and passes the scan token to its neighbor.
module svalloc_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [svalloc_pkg::VOICE_W-1:0]  my_idx,
  input  svalloc_pkg::ctl_t                ctl,
  input  svalloc_pkg::tok_t                tok_in,
  output svalloc_pkg::tok_t                tok_out,
  output svalloc_pkg::res_t                res
);

  logic                          on_r, on_nxt;
  logic                          held_r, held_nxt;
  logic [3:0]                    ch_r, ch_nxt;
  logic [6:0]                    note_r, note_nxt;
  logic [7:0]                    patch_r, patch_nxt;
  logic                          pv_r, pv_nxt;
  logic [svalloc_pkg::AGE_W-1:0] age_r, age_nxt;
  svalloc_pkg::tok_t             tok_r, tok_nxt;

  logic       active;
  logic [1:0] rank;
  logic       ch_hit;
  logic       sel_hit;

  assign active  = on_r | held_r;
  assign rank    = on_r ? svalloc_pkg::RANK_ON :
                   (held_r ? svalloc_pkg::RANK_HELD : svalloc_pkg::RANK_IDLE);
  assign ch_hit  = (ch_r == ctl.channel);
  assign sel_hit = (my_idx == ctl.sel);

  always_comb begin
    tok_nxt   = tok_in;
    res       = '0;
    on_nxt    = on_r;
    held_nxt  = held_r;
    ch_nxt    = ch_r;
    note_nxt  = note_r;
    patch_nxt = patch_r;
    pv_nxt    = pv_r;
    age_nxt   = age_r;

    if (tok_in.vld) begin
      case (ctl.mode)
        svalloc_pkg::SCAN_PICK: begin
          if (rank < tok_in.rank || (rank == tok_in.rank && age_r < tok_in.age)) begin
            tok_nxt.rank = rank;
            tok_nxt.age  = age_r;
            tok_nxt.idx  = my_idx;
          end
        end
        svalloc_pkg::SCAN_NOTE_OFF: begin
          // first sounding voice with this channel and note only
          if (!tok_in.done && on_r && ch_hit && note_r == ctl.note) begin
            tok_nxt.done = 1'b1;
            res.vld      = 1'b1;
            res.ev       = ctl.pedal ? svalloc_pkg::EV_HELD : svalloc_pkg::EV_KEY_OFF;
            on_nxt       = 1'b0;
            held_nxt     = ctl.pedal;
          end
        end
        svalloc_pkg::SCAN_REL_HELD: begin
          if (held_r && ch_hit) begin
            res.vld  = 1'b1;
            res.ev   = svalloc_pkg::EV_KEY_OFF;
            on_nxt   = 1'b0;
            held_nxt = 1'b0;
          end
        end
        svalloc_pkg::SCAN_CH_OFF: begin
          if (active && ch_hit) begin
            res.vld  = 1'b1;
            res.ev   = svalloc_pkg::EV_KEY_OFF;
            on_nxt   = 1'b0;
            held_nxt = 1'b0;
          end
        end
        svalloc_pkg::SCAN_ALL_OFF: begin
          if (active) begin
            res.vld  = 1'b1;
            res.ev   = svalloc_pkg::EV_KEY_OFF;
            on_nxt   = 1'b0;
            held_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
      res.channel = ch_r;
      res.note    = note_r;
    end

    if (sel_hit) begin
      case (ctl.op)
        svalloc_pkg::OP_KILL: begin
          if (active) begin
            res.vld     = 1'b1;
            res.ev      = svalloc_pkg::EV_KEY_OFF;
            res.channel = ch_r;
            res.note    = note_r;
            on_nxt      = 1'b0;
            held_nxt    = 1'b0;
          end
        end
        svalloc_pkg::OP_ALLOC: begin
          res.vld      = 1'b1;
          res.ev       = svalloc_pkg::EV_KEY_ON;
          res.channel  = ctl.channel;
          res.note     = ctl.note;
          res.velocity = ctl.velocity;
          res.reload   = !pv_r || (patch_r != ctl.patch);
          res.patch    = ctl.patch;
          on_nxt       = 1'b1;
          held_nxt     = 1'b0;
          ch_nxt       = ctl.channel;
          note_nxt     = ctl.note;
          patch_nxt    = ctl.patch;
          pv_nxt       = 1'b1;
          age_nxt      = ctl.age;
        end
        default: begin
        end
      endcase
    end

    res.voice = res.vld ? my_idx : '0;
    if (!res.vld) begin
      res.channel = '0;
      res.note    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      held_r  <= 1'b0;
      ch_r    <= '0;
      note_r  <= '0;
      patch_r <= '0;
      pv_r    <= 1'b0;
      age_r   <= '0;
      tok_r   <= '0;
    end else begin
      if (ctl.adv) begin
        on_r    <= on_nxt;
        held_r  <= held_nxt;
        ch_r    <= ch_nxt;
        note_r  <= note_nxt;
        patch_r <= patch_nxt;
        age_r   <= age_nxt;
        tok_r   <= tok_nxt;
      end
      if (ctl.clr_patch) begin
        pv_r <= 1'b0;
      end else if (ctl.adv) begin
        pv_r <= pv_nxt;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/svalloc_seq.sv =====
// Command decoder, pass sequencer, pedal flags, age counter and result output stage.
module svalloc_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_cmd,
  input  logic [3:0]                      in_channel,
  input  logic [6:0]                      in_note,
  input  logic [6:0]                      in_velocity,
  input  logic [7:0]                      in_patch_id,
  input  logic                            in_patch_present,
  input  logic [6:0]                      in_pedal_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_event_res,
  output logic [4:0]                      out_voice,
  output logic [3:0]                      out_channel,
  output logic [6:0]                      out_note,
  output logic [6:0]                      out_velocity,
  output logic                            out_reload_patch,
  output logic [7:0]                      out_patch,
  output logic                            out_last,
  output svalloc_pkg::ctl_t               ctl,
  output svalloc_pkg::tok_t               tok_first,
  input  svalloc_pkg::tok_t               tok_last,
  input  svalloc_pkg::res_t               cell_res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_KILL  = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]                            state_r, state_nxt;
  logic [2:0]                            mode_r, mode_nxt;
  logic [3:0]                            ch_r;
  logic [6:0]                            note_r;
  logic [6:0]                            vel_r;
  logic [7:0]                            pid_r;
  logic                                  pedal_r, pedal_nxt;
  logic [svalloc_pkg::VOICE_W-1:0]       sel_r, sel_nxt;
  logic [svalloc_pkg::AGE_W-1:0]         age_cnt_r, age_cnt_nxt;
  logic [svalloc_pkg::NUM_CHANNELS-1:0]  pedal_down_r, pedal_down_nxt;
  svalloc_pkg::tok_t                     tok0_r;
  svalloc_pkg::tok_t                     tok_seed;
  svalloc_pkg::res_t                     pend_r, pend_nxt;
  svalloc_pkg::res_t                     out_r, out_nxt;
  logic                                  out_last_r, out_last_nxt;

  logic accept;
  logic can_push;
  logic start;
  logic ch_ok;
  logic emit;
  logic flush_push;
  logic clr_patch;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_push = !out_r.vld || !out_stall;
  assign ch_ok    = int'(in_channel) < svalloc_pkg::NUM_CHANNELS;
  assign emit     = cell_res.vld && can_push;
  assign flush_push = (state_r == ST_FLUSH) && pend_r.vld && can_push;

  // Fresh token: valid, worst rank so the first cell always wins
  always_comb begin
    tok_seed      = '0;
    tok_seed.vld  = 1'b1;
    tok_seed.rank = svalloc_pkg::RANK_NONE;
  end

  // Decode the command and pick the pass to run
  always_comb begin
    start          = 1'b0;
    mode_nxt       = mode_r;
    pedal_nxt      = pedal_r;
    pedal_down_nxt = pedal_down_r;
    clr_patch      = 1'b0;
    if (accept) begin
      unique case (in_cmd)
        svalloc_pkg::CMD_NOTE_ON: begin
          if (ch_ok) begin
            if (in_velocity == 7'd0) begin
              start     = 1'b1;
              mode_nxt  = svalloc_pkg::SCAN_NOTE_OFF;
              pedal_nxt = pedal_down_r[in_channel];
            end else if (in_patch_present) begin
              start    = 1'b1;
              mode_nxt = svalloc_pkg::SCAN_PICK;
            end
          end
        end
        svalloc_pkg::CMD_NOTE_OFF: begin
          if (ch_ok) begin
            start     = 1'b1;
            mode_nxt  = svalloc_pkg::SCAN_NOTE_OFF;
            pedal_nxt = pedal_down_r[in_channel];
          end
        end
        svalloc_pkg::CMD_PEDAL: begin
          if (ch_ok) begin
            pedal_down_nxt[in_channel] = (int'(in_pedal_value) >= svalloc_pkg::PEDAL_THRESHOLD);
            if (int'(in_pedal_value) < svalloc_pkg::PEDAL_THRESHOLD) begin
              start    = 1'b1;
              mode_nxt = svalloc_pkg::SCAN_REL_HELD;
            end
          end
        end
        svalloc_pkg::CMD_ALL_NOTES_OFF: begin
          if (ch_ok) begin
            start    = 1'b1;
            mode_nxt = svalloc_pkg::SCAN_CH_OFF;
          end
        end
        svalloc_pkg::CMD_RESET_CTRL: begin
          if (ch_ok) begin
            pedal_down_nxt[in_channel] = 1'b0;
            start    = 1'b1;
            mode_nxt = svalloc_pkg::SCAN_REL_HELD;
          end
        end
        svalloc_pkg::CMD_ALL_OFF: begin
          pedal_down_nxt = '0;
          start          = 1'b1;
          mode_nxt       = svalloc_pkg::SCAN_ALL_OFF;
        end
        svalloc_pkg::CMD_BANK_CHANGE: begin
          pedal_down_nxt = '0;
          clr_patch      = 1'b1;
          start          = 1'b1;
          mode_nxt       = svalloc_pkg::SCAN_ALL_OFF;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    age_cnt_nxt = age_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // token has left the last cell
        if (can_push && tok_last.vld) begin
          if (mode_r == svalloc_pkg::SCAN_PICK) begin
            sel_nxt   = tok_last.idx;
            state_nxt = ST_KILL;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_KILL: begin
        if (can_push) state_nxt = ST_ALLOC;
      end
      ST_ALLOC: begin
        if (can_push) begin
          age_cnt_nxt = age_cnt_r + svalloc_pkg::AGE_W'(1);
          state_nxt   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_r.vld || can_push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the newest result back until it is known whether another follows
  always_comb begin
    pend_nxt     = pend_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (emit && pend_r.vld) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b0;
    end else if (flush_push) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
    end else if (!out_stall) begin
      out_nxt.vld = 1'b0;
    end
    if (emit) begin
      pend_nxt = cell_res;
    end else if (flush_push) begin
      pend_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= svalloc_pkg::SCAN_PICK;
      pedal_r      <= 1'b0;
      sel_r        <= '0;
      age_cnt_r    <= '0;
      pedal_down_r <= '0;
      tok0_r       <= '0;
      pend_r       <= '0;
      out_r        <= '0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      pedal_r      <= pedal_nxt;
      sel_r        <= sel_nxt;
      age_cnt_r    <= age_cnt_nxt;
      pedal_down_r <= pedal_down_nxt;
      pend_r       <= pend_nxt;
      out_r        <= out_nxt;
      out_last_r   <= out_last_nxt;
      if (start) begin
        tok0_r <= tok_seed;
      end else if (can_push) begin
        tok0_r.vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= in_channel;
      note_r <= in_note;
      vel_r  <= in_velocity;
      pid_r  <= in_patch_id;
    end
  end

  always_comb begin
    ctl           = '0;
    ctl.adv       = can_push;
    ctl.mode      = mode_r;
    ctl.channel   = ch_r;
    ctl.note      = note_r;
    ctl.pedal     = pedal_r;
    ctl.op        = (state_r == ST_KILL)  ? svalloc_pkg::OP_KILL :
                    (state_r == ST_ALLOC) ? svalloc_pkg::OP_ALLOC : svalloc_pkg::OP_NONE;
    ctl.sel       = sel_r;
    ctl.velocity  = vel_r;
    ctl.patch     = pid_r;
    ctl.age       = age_cnt_r + svalloc_pkg::AGE_W'(1);
    ctl.clr_patch = clr_patch;
  end

  assign tok_first        = tok0_r;
  assign out_valid        = out_r.vld;
  assign out_event_res    = out_r.ev;
  assign out_voice        = out_r.voice;
  assign out_channel      = out_r.channel;
  assign out_note         = out_r.note;
  assign out_velocity     = out_r.velocity;
  assign out_reload_patch = out_r.reload;
  assign out_patch        = out_r.patch;
  assign out_last         = out_last_r;

endmodule

// ===== src/synth_voice_allocator_core.sv =====
// Voice allocator top level: cell chain plus sequencer.
//
// Input channel (in_valid/in_stall) takes one MIDI event per transaction;
// result channel (out_valid/out_stall) gives key_on, key_off and held events,
// out_last marking the final one for an event. No configuration port.
// Each voice lives in its own cell. An event starts a scan token that walks
// the chain one cell per cycle; cells it passes key off, hold or compete for
// allocation. A note-on then keys off the chosen voice if busy and keys it on.
// An event that is ignored or produces no scan leaves in_stall low.
// in_stall stays high until all of an event's results are queued; the next
// event is taken while the last result still waits in the output register.
// Receiver stall freezes the token walk and all voice updates in place.
// Reset (synchronous, rst_n low) silences every voice, clears cached patches,
// ages, pedal flags and the age counter; no results are pending afterwards.
module synth_voice_allocator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_channel,
  input  logic [6:0] in_note,
  input  logic [6:0] in_velocity,
  input  logic [7:0] in_patch_id,
  input  logic       in_patch_present,
  input  logic [6:0] in_pedal_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [4:0] out_voice,
  output logic [3:0] out_channel,
  output logic [6:0] out_note,
  output logic [6:0] out_velocity,
  output logic       out_reload_patch,
  output logic [7:0] out_patch,
  output logic       out_last
);

  svalloc_pkg::ctl_t ctl;
  svalloc_pkg::tok_t tok [svalloc_pkg::NUM_VOICES+1];
  svalloc_pkg::res_t cell_res [svalloc_pkg::NUM_VOICES];
  svalloc_pkg::res_t res_any;

  svalloc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_channel       (in_channel),
    .in_note          (in_note),
    .in_velocity      (in_velocity),
    .in_patch_id      (in_patch_id),
    .in_patch_present (in_patch_present),
    .in_pedal_value   (in_pedal_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_voice        (out_voice),
    .out_channel      (out_channel),
    .out_note         (out_note),
    .out_velocity     (out_velocity),
    .out_reload_patch (out_reload_patch),
    .out_patch        (out_patch),
    .out_last         (out_last),
    .ctl              (ctl),
    .tok_first        (tok[0]),
    .tok_last         (tok[svalloc_pkg::NUM_VOICES]),
    .cell_res         (res_any)
  );

  for (genvar i = 0; i < svalloc_pkg::NUM_VOICES; i++) begin : g_cell
    svalloc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (svalloc_pkg::VOICE_W'(i)),
      .ctl     (ctl),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .res     (cell_res[i])
    );
  end

  // At most one cell reports in a cycle
  always_comb begin
    res_any = '0;
    for (int i = 0; i < svalloc_pkg::NUM_VOICES; i++) begin
      res_any = res_any | cell_res[i];
    end
  end

endmodule

// ===== src/svalloc_chk.sv =====
// Port-level checker for the voice allocator, bound to the top level.
module svalloc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_event_res,
  input logic [4:0] out_voice,
  input logic [3:0] out_channel,
  input logic [6:0] out_note,
  input logic [6:0] out_velocity,
  input logic       out_reload_patch,
  input logic [7:0] out_patch,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_event_res, out_voice, out_channel, out_note, out_velocity,
               out_reload_patch, out_patch, out_last}))
    else $error("result changed while stalled");

  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_voice) < svalloc_pkg::NUM_VOICES)
    else $error("voice index out of range");

  a_key_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == svalloc_pkg::EV_KEY_ON |-> out_last)
    else $error("key_on is not the final result of its event");

  a_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != svalloc_pkg::EV_KEY_ON |->
      (out_event_res == svalloc_pkg::EV_KEY_OFF || out_event_res == svalloc_pkg::EV_HELD) &&
      out_velocity == 7'd0 && out_patch == 8'd0 && !out_reload_patch)
    else $error("key_off or held result carries key_on fields");

endmodule

bind synth_voice_allocator_core svalloc_chk u_svalloc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_res    (out_event_res),
  .out_voice        (out_voice),
  .out_channel      (out_channel),
  .out_note         (out_note),
  .out_velocity     (out_velocity),
  .out_reload_patch (out_reload_patch),
  .out_patch        (out_patch),
  .out_last         (out_last)
);
